@@ rtl/chained_bucket_table_engine_assert.svh @@
// Assertion macros for the chained bucket table engine.
// Used by the top level only; no other dependencies.
`ifndef CHAINED_BUCKET_TABLE_ENGINE_ASSERT_SVH
`define CHAINED_BUCKET_TABLE_ENGINE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CBT_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cbt: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define CBT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cbt: next-cycle check failed");

`endif

@@ rtl/cbt_pkg.sv @@
// Shared types and codes for the chained bucket table engine.
// No dependencies.
`default_nettype none

package cbt_pkg;

  // input mode codes
  localparam logic [2:0] MODE_INSERT       = 3'd0;
  localparam logic [2:0] MODE_LOOKUP       = 3'd1;
  localparam logic [2:0] MODE_REMOVE_VAL   = 3'd2;
  localparam logic [2:0] MODE_REMOVE_SLOT  = 3'd3;
  localparam logic [2:0] MODE_READ         = 3'd4;

  // command queue depth (power of two)
  localparam int QDEPTH = 2;

  // classified operation
  typedef enum logic [2:0] {
    OP_INSERT,
    OP_LOOKUP,
    OP_REMOVE_VAL,
    OP_REMOVE_SLOT,
    OP_READ,
    OP_NOT_FOUND,
    OP_SLOT_EMPTY
  } op_t;

  typedef enum logic [2:0] {
    ST_INSERTED   = 3'd0,
    ST_FOUND      = 3'd1,
    ST_NOT_FOUND  = 3'd2,
    ST_FULL       = 3'd3,
    ST_REMOVED    = 3'd4,
    ST_SLOT_EMPTY = 3'd5,
    ST_READ       = 3'd6
  } status_t;

  typedef struct packed {
    op_t         op;
    logic [5:0]  bucket;
    logic [31:0] value;
    logic [7:0]  slot;
  } cmd_t;

  typedef struct packed {
    logic clearing;
    logic idle;
  } back_stat_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HEAD,
    S_WALK,
    S_MISS,
    S_POP,
    S_INS,
    S_LINK,
    S_SLOT,
    S_UNLINK,
    S_OUT
  } state_t;

endpackage

`default_nettype wire

@@ rtl/cbt_front.sv @@
// Front end: takes input items, classifies them and hands commands to the queue.
// Depends on cbt_pkg.
`default_nettype none

module cbt_front #(
  parameter int BUCKETS   = 64,
  parameter int POOL_SIZE = 256
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire logic [2:0]   mode,
  input  wire logic [5:0]   bucket,
  input  wire logic [31:0]  value,
  input  wire logic [7:0]   slot,
  output logic              q_push,
  output cbt_pkg::cmd_t     q_cmd,
  input  wire logic         q_full
);

  cbt_pkg::cmd_t cmd_next;
  cbt_pkg::cmd_t hold;
  logic          hold_v;
  logic          bucket_ok;
  logic          slot_ok;
  logic          load;

  // range checks against the configured table size
  assign bucket_ok = {26'd0, bucket} < 32'(BUCKETS);
  assign slot_ok   = {24'd0, slot} < 32'(POOL_SIZE);

  // classify
  always_comb begin
    cmd_next.bucket = bucket;
    cmd_next.value  = value;
    cmd_next.slot   = slot;
    case (mode)
      cbt_pkg::MODE_INSERT:
        cmd_next.op = bucket_ok ? cbt_pkg::OP_INSERT : cbt_pkg::OP_NOT_FOUND;
      cbt_pkg::MODE_LOOKUP:
        cmd_next.op = bucket_ok ? cbt_pkg::OP_LOOKUP : cbt_pkg::OP_NOT_FOUND;
      cbt_pkg::MODE_REMOVE_VAL:
        cmd_next.op = bucket_ok ? cbt_pkg::OP_REMOVE_VAL : cbt_pkg::OP_NOT_FOUND;
      cbt_pkg::MODE_REMOVE_SLOT:
        cmd_next.op = slot_ok ? cbt_pkg::OP_REMOVE_SLOT : cbt_pkg::OP_SLOT_EMPTY;
      cbt_pkg::MODE_READ:
        cmd_next.op = slot_ok ? cbt_pkg::OP_READ : cbt_pkg::OP_SLOT_EMPTY;
      default:
        cmd_next.op = cbt_pkg::OP_NOT_FOUND;
    endcase
  end

  // one holding register ahead of the queue
  assign in_stall = hold_v && q_full;
  assign load     = in_valid && !in_stall;
  assign q_push   = hold_v && !q_full;
  assign q_cmd    = hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_v <= 1'b0;
    end else if (load) begin
      hold_v <= 1'b1;
    end else if (q_push) begin
      hold_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hold <= cmd_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/cbt_queue.sv @@
// Short command queue between front and back ends.
// Depends on cbt_pkg.
`default_nettype none

module cbt_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire cbt_pkg::cmd_t push_cmd,
  output logic               full,
  input  wire logic          pop,
  output cbt_pkg::cmd_t      pop_cmd,
  output logic               not_empty
);

  localparam int AW = (cbt_pkg::QDEPTH > 1) ? $clog2(cbt_pkg::QDEPTH) : 1;

  cbt_pkg::cmd_t  mem [cbt_pkg::QDEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [AW:0]    cnt;

  assign full      = cnt == (AW+1)'(cbt_pkg::QDEPTH);
  assign not_empty = cnt != '0;
  assign pop_cmd   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

@@ rtl/cbt_back.sv @@
// Back end: bucket heads, entry pool, link memories, free stack and sequencer.
// Depends on cbt_pkg.
`default_nettype none

module cbt_back #(
  parameter int BUCKETS    = 64,
  parameter int POOL_SIZE  = 256,
  parameter int VALUE_BITS = 32
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_valid,
  input  wire cbt_pkg::cmd_t q_cmd,
  output logic               q_pop,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [2:0]         status,
  output logic [7:0]         result_slot,
  output logic [31:0]        result_value,
  output logic [5:0]         result_bucket,
  output cbt_pkg::back_stat_t bstat
);

  localparam int PW = $clog2(POOL_SIZE);
  localparam int LW = PW + 1;
  localparam int CW = PW + 1;
  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int VB = (VALUE_BITS < 32) ? VALUE_BITS : 32;
  localparam int DW = 1 + BW + VB;
  localparam logic [LW-1:0] NIL = LW'(POOL_SIZE);

  // memories
  logic [LW-1:0] head_mem [BUCKETS];
  logic [LW-1:0] next_mem [POOL_SIZE];
  logic [LW-1:0] prev_mem [POOL_SIZE];
  logic [DW-1:0] data_mem [POOL_SIZE];
  logic [PW-1:0] stk_mem  [POOL_SIZE];

  logic          head_we, next_we, prev_we, data_we, stk_we;
  logic [BW-1:0] head_wa, head_ra;
  logic [PW-1:0] next_wa, prev_wa, data_wa, stk_wa;
  logic [PW-1:0] next_ra, prev_ra, data_ra, stk_ra;
  logic [LW-1:0] head_wd, next_wd, prev_wd;
  logic [DW-1:0] data_wd;
  logic [PW-1:0] stk_wd;
  logic [LW-1:0] head_rd, next_rd, prev_rd;
  logic [DW-1:0] data_rd;
  logic [PW-1:0] stk_rd;

  // control and result registers
  cbt_pkg::state_t  state, state_next;
  logic [BW-1:0]    clr, clr_next;
  cbt_pkg::cmd_t    cmd, cmd_next;
  logic [PW-1:0]    cur, cur_next;
  logic [LW-1:0]    head_val, head_val_next;
  logic [LW-1:0]    nx, nx_next;
  logic [LW-1:0]    pv, pv_next;
  logic [BW-1:0]    eb, eb_next;
  logic [PW-1:0]    newh, newh_next;
  logic [CW-1:0]    stk_cnt, stk_cnt_next;
  logic [CW-1:0]    fresh, fresh_next;
  cbt_pkg::status_t res_status, res_status_next;
  logic [7:0]       res_slot, res_slot_next;
  logic [31:0]      res_value, res_value_next;
  logic [5:0]       res_bucket, res_bucket_next;

  logic          d_used;
  logic [BW-1:0] d_bucket;
  logic [VB-1:0] d_value;
  logic          used_ok;
  logic          hit;
  logic          pool_full;

  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    head_rd <= head_mem[head_ra];
  end

  always_ff @(posedge clk) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    next_rd <= next_mem[next_ra];
  end

  always_ff @(posedge clk) begin
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    prev_rd <= prev_mem[prev_ra];
  end

  always_ff @(posedge clk) begin
    if (data_we) data_mem[data_wa] <= data_wd;
    data_rd <= data_mem[data_ra];
  end

  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    stk_rd <= stk_mem[stk_ra];
  end

  // entry fields; handles at or above the fresh mark were never allocated
  assign d_used    = data_rd[DW-1];
  assign d_bucket  = data_rd[DW-2 -: BW];
  assign d_value   = data_rd[VB-1:0];
  assign used_ok   = d_used && ({1'b0, cur} < fresh);
  assign hit       = used_ok && (d_value == cmd.value[VB-1:0]);
  // free stack = pushed handles on top of never-used handles
  assign pool_full = (stk_cnt == '0) && (fresh == CW'(POOL_SIZE));

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= cbt_pkg::S_CLEAR;
      clr     <= '0;
      stk_cnt <= '0;
      fresh   <= '0;
    end else begin
      state   <= state_next;
      clr     <= clr_next;
      stk_cnt <= stk_cnt_next;
      fresh   <= fresh_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd        <= cmd_next;
    cur        <= cur_next;
    head_val   <= head_val_next;
    nx         <= nx_next;
    pv         <= pv_next;
    eb         <= eb_next;
    newh       <= newh_next;
    res_status <= res_status_next;
    res_slot   <= res_slot_next;
    res_value  <= res_value_next;
    res_bucket <= res_bucket_next;
  end

  // sequencer
  always_comb begin
    state_next      = state;
    clr_next        = clr;
    cmd_next        = cmd;
    cur_next        = cur;
    head_val_next   = head_val;
    nx_next         = nx;
    pv_next         = pv;
    eb_next         = eb;
    newh_next       = newh;
    stk_cnt_next    = stk_cnt;
    fresh_next      = fresh;
    res_status_next = res_status;
    res_slot_next   = res_slot;
    res_value_next  = res_value;
    res_bucket_next = res_bucket;
    q_pop   = 1'b0;
    head_we = 1'b0; head_wa = '0; head_wd = '0; head_ra = '0;
    next_we = 1'b0; next_wa = '0; next_wd = '0; next_ra = cur;
    prev_we = 1'b0; prev_wa = '0; prev_wd = '0; prev_ra = cur;
    data_we = 1'b0; data_wa = '0; data_wd = '0; data_ra = cur;
    stk_we  = 1'b0; stk_wa  = '0; stk_wd  = '0; stk_ra  = '0;

    case (state)
      // mark every bucket empty after reset
      cbt_pkg::S_CLEAR: begin
        head_we = 1'b1;
        head_wa = clr;
        head_wd = NIL;
        if (clr == BW'(BUCKETS - 1)) begin
          state_next = cbt_pkg::S_IDLE;
        end else begin
          clr_next = clr + 1'b1;
        end
      end

      cbt_pkg::S_IDLE: begin
        head_ra = BW'(q_cmd.bucket);
        next_ra = PW'(q_cmd.slot);
        prev_ra = PW'(q_cmd.slot);
        data_ra = PW'(q_cmd.slot);
        if (q_valid) begin
          q_pop           = 1'b1;
          cmd_next        = q_cmd;
          cur_next        = PW'(q_cmd.slot);
          res_slot_next   = '0;
          res_value_next  = '0;
          res_bucket_next = '0;
          case (q_cmd.op)
            cbt_pkg::OP_INSERT, cbt_pkg::OP_LOOKUP, cbt_pkg::OP_REMOVE_VAL:
              state_next = cbt_pkg::S_HEAD;
            cbt_pkg::OP_REMOVE_SLOT, cbt_pkg::OP_READ:
              state_next = cbt_pkg::S_SLOT;
            cbt_pkg::OP_SLOT_EMPTY: begin
              res_status_next = cbt_pkg::ST_SLOT_EMPTY;
              state_next      = cbt_pkg::S_OUT;
            end
            default: begin
              res_status_next = cbt_pkg::ST_NOT_FOUND;
              state_next      = cbt_pkg::S_OUT;
            end
          endcase
        end
      end

      // chain head arrives
      cbt_pkg::S_HEAD: begin
        head_val_next = head_rd;
        next_ra = head_rd[PW-1:0];
        prev_ra = head_rd[PW-1:0];
        data_ra = head_rd[PW-1:0];
        if (head_rd == NIL) begin
          state_next = cbt_pkg::S_MISS;
        end else begin
          cur_next   = head_rd[PW-1:0];
          state_next = cbt_pkg::S_WALK;
        end
      end

      // one chain link per cycle
      cbt_pkg::S_WALK: begin
        next_ra = next_rd[PW-1:0];
        prev_ra = next_rd[PW-1:0];
        data_ra = next_rd[PW-1:0];
        if (hit) begin
          nx_next       = next_rd;
          pv_next       = prev_rd;
          eb_next       = d_bucket;
          res_slot_next = 8'(cur);
          if (cmd.op == cbt_pkg::OP_REMOVE_VAL) begin
            state_next = cbt_pkg::S_UNLINK;
          end else begin
            res_status_next = cbt_pkg::ST_FOUND;
            state_next      = cbt_pkg::S_OUT;
          end
        end else if (next_rd == NIL) begin
          state_next = cbt_pkg::S_MISS;
        end else begin
          cur_next = next_rd[PW-1:0];
        end
      end

      // value absent; insert allocates a handle unless the pool is full
      cbt_pkg::S_MISS: begin
        stk_ra = PW'(stk_cnt - 1'b1);
        if (cmd.op != cbt_pkg::OP_INSERT) begin
          res_status_next = cbt_pkg::ST_NOT_FOUND;
          state_next      = cbt_pkg::S_OUT;
        end else if (pool_full) begin
          res_status_next = cbt_pkg::ST_FULL;
          state_next      = cbt_pkg::S_OUT;
        end else if (stk_cnt != '0) begin
          stk_cnt_next = stk_cnt - 1'b1;
          state_next   = cbt_pkg::S_POP;
        end else begin
          newh_next  = fresh[PW-1:0];
          fresh_next = fresh + 1'b1;
          state_next = cbt_pkg::S_INS;
        end
      end

      cbt_pkg::S_POP: begin
        newh_next  = stk_rd;
        state_next = cbt_pkg::S_INS;
      end

      // write new entry and make it the chain head
      cbt_pkg::S_INS: begin
        data_we = 1'b1;
        data_wa = newh;
        data_wd = {1'b1, BW'(cmd.bucket), cmd.value[VB-1:0]};
        next_we = 1'b1;
        next_wa = newh;
        next_wd = head_val;
        prev_we = 1'b1;
        prev_wa = newh;
        prev_wd = NIL;
        head_we = 1'b1;
        head_wa = BW'(cmd.bucket);
        head_wd = {1'b0, newh};
        res_status_next = cbt_pkg::ST_INSERTED;
        res_slot_next   = 8'(newh);
        state_next = (head_val != NIL) ? cbt_pkg::S_LINK : cbt_pkg::S_OUT;
      end

      // back link of the old head
      cbt_pkg::S_LINK: begin
        prev_we    = 1'b1;
        prev_wa    = head_val[PW-1:0];
        prev_wd    = {1'b0, newh};
        state_next = cbt_pkg::S_OUT;
      end

      // entry addressed by handle arrives
      cbt_pkg::S_SLOT: begin
        if (used_ok) begin
          res_slot_next = 8'(cur);
          if (cmd.op == cbt_pkg::OP_READ) begin
            res_status_next = cbt_pkg::ST_READ;
            res_value_next  = 32'(d_value);
            res_bucket_next = 6'(d_bucket);
            state_next      = cbt_pkg::S_OUT;
          end else begin
            nx_next    = next_rd;
            pv_next    = prev_rd;
            eb_next    = d_bucket;
            state_next = cbt_pkg::S_UNLINK;
          end
        end else begin
          res_status_next = cbt_pkg::ST_SLOT_EMPTY;
          state_next      = cbt_pkg::S_OUT;
        end
      end

      // splice out, mark unused, push handle on the free stack
      cbt_pkg::S_UNLINK: begin
        if (pv != NIL) begin
          next_we = 1'b1;
          next_wa = pv[PW-1:0];
          next_wd = nx;
        end else begin
          head_we = 1'b1;
          head_wa = eb;
          head_wd = nx;
        end
        if (nx != NIL) begin
          prev_we = 1'b1;
          prev_wa = nx[PW-1:0];
          prev_wd = pv;
        end
        data_we = 1'b1;
        data_wa = cur;
        data_wd = {1'b0, eb, VB'(0)};
        stk_we  = 1'b1;
        stk_wa  = stk_cnt[PW-1:0];
        stk_wd  = cur;
        stk_cnt_next    = stk_cnt + 1'b1;
        res_status_next = cbt_pkg::ST_REMOVED;
        state_next      = cbt_pkg::S_OUT;
      end

      cbt_pkg::S_OUT: begin
        if (!out_stall) begin
          state_next = cbt_pkg::S_IDLE;
        end
      end

      default: state_next = cbt_pkg::S_IDLE;
    endcase
  end

  assign out_valid      = state == cbt_pkg::S_OUT;
  assign status         = res_status;
  assign result_slot    = res_slot;
  assign result_value   = res_value;
  assign result_bucket  = res_bucket;
  assign bstat.clearing = state == cbt_pkg::S_CLEAR;
  assign bstat.idle     = state == cbt_pkg::S_IDLE;

endmodule

`default_nettype wire

@@ rtl/chained_bucket_table_engine.sv @@
// Top level of the chained bucket table engine: front, command queue, back.
// Depends on cbt_pkg, cbt_front, cbt_queue, cbt_back and the assertion header.
//
//   channel   valid      stall      payload
//   input     in_valid   in_stall   mode, bucket, value, slot
//   output    out_valid  out_stall  status, result_slot, result_value, result_bucket
//
// In the back end, lookup and remove by value walk the chain, one link per cycle;
// a miss and a remove each add a step. A new insert also takes a handle, writes the
// entry and links the old head; read and remove by handle go straight to the entry,
// and a bad mode, bucket or slot is answered without touching the table. The chain
// walk sets the rate. After reset the bucket heads are cleared; the front still takes
// up to three items meanwhile. A stalled result holds the back end; the front keeps
// taking items until the queue and its holding register are full.
`default_nettype none

module chained_bucket_table_engine #(
  parameter int BUCKETS    = 64,
  parameter int POOL_SIZE  = 256,
  parameter int VALUE_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  mode,
  input  wire logic [5:0]  bucket,
  input  wire logic [31:0] value,
  input  wire logic [7:0]  slot,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       status,
  output logic [7:0]       result_slot,
  output logic [31:0]      result_value,
  output logic [5:0]       result_bucket
);

`include "chained_bucket_table_engine_assert.svh"

  logic                q_push;
  cbt_pkg::cmd_t       push_cmd;
  logic                q_full;
  logic                q_pop;
  cbt_pkg::cmd_t       q_cmd;
  logic                q_valid;
  cbt_pkg::back_stat_t bstat;
  logic                quick_pop;

  cbt_front #(
    .BUCKETS   (BUCKETS),
    .POOL_SIZE (POOL_SIZE)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .mode     (mode),
    .bucket   (bucket),
    .value    (value),
    .slot     (slot),
    .q_push   (q_push),
    .q_cmd    (push_cmd),
    .q_full   (q_full)
  );

  cbt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_cmd   (q_cmd),
    .not_empty (q_valid)
  );

  cbt_back #(
    .BUCKETS    (BUCKETS),
    .POOL_SIZE  (POOL_SIZE),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_cmd         (q_cmd),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .result_slot   (result_slot),
    .result_value  (result_value),
    .result_bucket (result_bucket),
    .bstat         (bstat)
  );

  // items answered without touching the table
  assign quick_pop = q_pop && (q_cmd.op == cbt_pkg::OP_NOT_FOUND ||
                               q_cmd.op == cbt_pkg::OP_SLOT_EMPTY);

  // checks
  `CBT_ASSERT_NOW(a_no_pop_while_clearing, clk, rst, bstat.clearing, !q_pop)
  `CBT_ASSERT_NOW(a_pop_only_when_idle, clk, rst, q_pop, bstat.idle && q_valid)
  `CBT_ASSERT_NEXT(a_quick_answer, clk, rst, quick_pop, out_valid)
  `CBT_ASSERT_NEXT(a_single_result, clk, rst, out_valid && !out_stall, !out_valid)

endmodule

`default_nettype wire
